// ----- src/rsdh_pkg.sv -----
package rsdh_pkg;

    localparam int COORD_W  = 24;
    localparam int RADIUS_W = 23;
    localparam int WEIGHT_W = 32;
    localparam int TYPE_W   = 8;
    localparam int ECNT_W   = 5;
    localparam int EIDX_W   = 4;
    localparam int SHELL_W  = 4;
    localparam int DENS_W   = 32;
    localparam int SQ_W     = 2 * RADIUS_W;
    localparam int R2_W     = 2 * COORD_W;
    localparam int SUM_W    = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_CHARGE = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_Z_MIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Z_MAX      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEL_TYPE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_COUNT = 2'd3;

    localparam logic [ECNT_W-1:0] ECOUNT_RESET = 5'd2;

    // pi in Q2.30
    localparam logic [31:0] PI_Q30 = 32'd3373259426;

    typedef struct packed {
        logic signed [COORD_W-1:0] z_min;
        logic signed [COORD_W-1:0] z_max;
        logic [TYPE_W-1:0]         sel_type;
        logic [ECNT_W-1:0]         edge_count;
    } cfg_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [EIDX_W-1:0]   edge_idx;
        logic [RADIUS_W-1:0] radius;
        logic [R2_W-1:0]     r2;
        logic [WEIGHT_W-1:0] weight;
    } job_t;

endpackage

// ----- src/rsdh_front.sv -----
module rsdh_front #(
    parameter int MAX_EDGES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        kind,
    input  logic [rsdh_pkg::EIDX_W-1:0]       edge_index,
    input  logic [rsdh_pkg::RADIUS_W-1:0]     edge_radius,
    input  logic signed [rsdh_pkg::COORD_W-1:0] pos_x,
    input  logic signed [rsdh_pkg::COORD_W-1:0] pos_y,
    input  logic signed [rsdh_pkg::COORD_W-1:0] pos_z,
    input  logic [rsdh_pkg::TYPE_W-1:0]       charge_type,
    input  logic [rsdh_pkg::WEIGHT_W-1:0]     weight,
    input  logic                              cfg_we,
    input  logic [rsdh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsdh_pkg::CFG_DATA_W-1:0]   cfg_data,
    output rsdh_pkg::cfg_t                    cfg,
    output logic                              job_valid,
    input  logic                              job_ready,
    output rsdh_pkg::job_t                    job
);
    import rsdh_pkg::*;

    cfg_t cfg_reg;

    logic                       a_valid_reg;
    logic [1:0]                 a_kind_reg;
    logic [EIDX_W-1:0]          a_idx_reg;
    logic [RADIUS_W-1:0]        a_radius_reg;
    logic signed [COORD_W-1:0]  a_x_reg;
    logic signed [COORD_W-1:0]  a_y_reg;
    logic signed [COORD_W-1:0]  a_z_reg;
    logic [TYPE_W-1:0]          a_type_reg;
    logic [WEIGHT_W-1:0]        a_weight_reg;

    logic signed [R2_W-1:0] xx;
    logic signed [R2_W-1:0] yy;
    logic                   keep;
    logic                   a_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.z_min      <= '0;
            cfg_reg.z_max      <= '0;
            cfg_reg.sel_type   <= '0;
            cfg_reg.edge_count <= ECOUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_Z_MIN:      cfg_reg.z_min      <= cfg_data;
                REG_Z_MAX:      cfg_reg.z_max      <= cfg_data;
                REG_SEL_TYPE:   cfg_reg.sel_type   <= cfg_data[TYPE_W-1:0];
                REG_EDGE_COUNT: cfg_reg.edge_count <= cfg_data[ECNT_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    assign xx = a_x_reg * a_x_reg;
    assign yy = a_y_reg * a_y_reg;

    always_comb
    begin
        case (a_kind_reg)
            KIND_LOAD:   keep = (32'(a_idx_reg) < MAX_EDGES);
            KIND_CHARGE: keep = (a_type_reg == cfg_reg.sel_type) &&
                                (a_z_reg >= cfg_reg.z_min) && (a_z_reg < cfg_reg.z_max);
            KIND_FINISH: keep = 1'b1;
            default:     keep = 1'b0;
        endcase
    end

    assign job_valid = a_valid_reg && keep;
    assign a_adv     = a_valid_reg && (!keep || job_ready);
    assign in_ready  = !a_valid_reg || a_adv;

    assign job.kind     = a_kind_reg;
    assign job.edge_idx = a_idx_reg;
    assign job.radius   = a_radius_reg;
    assign job.r2       = xx + yy;
    assign job.weight   = a_weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_kind_reg   <= kind;
            a_idx_reg    <= edge_index;
            a_radius_reg <= edge_radius;
            a_x_reg      <= pos_x;
            a_y_reg      <= pos_y;
            a_z_reg      <= pos_z;
            a_type_reg   <= charge_type;
            a_weight_reg <= weight;
        end
    end

endmodule

// ----- src/rsdh_queue.sv -----
module rsdh_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rsdh_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rsdh_pkg::job_t pop_job
);
    import rsdh_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- src/rsdh_back.sv -----
module rsdh_back #(
    parameter int MAX_EDGES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  rsdh_pkg::job_t                job,
    input  rsdh_pkg::cfg_t                cfg,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rsdh_pkg::SHELL_W-1:0]  shell_index,
    output logic [rsdh_pkg::DENS_W-1:0]   density,
    output logic                          saturated,
    output logic                          last
);
    import rsdh_pkg::*;

    localparam int NS   = MAX_EDGES - 1;
    localparam int IW   = $clog2(MAX_EDGES);
    localparam int NW   = $clog2(MAX_EDGES + 1);
    localparam int NW1  = NW + 1;
    localparam int DZ_W = COORD_W + 1;
    localparam int MC_W = 102;
    localparam int RM_W = MC_W + 1;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CHG   = 8'b0000_0010,
        ST_FLOAD = 8'b0000_0100,
        ST_MUL1  = 8'b0000_1000,
        ST_MUL2  = 8'b0001_0000,
        ST_CHK   = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    state_t state_reg;

    logic [SQ_W-1:0]     sq_reg   [MAX_EDGES];
    logic [SUM_W-1:0]    sums_reg [NS];

    logic [IW-1:0]       hit_idx_reg;
    logic                hit_any_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [IW-1:0]       i_reg;
    logic [4:0]          cnt_reg;
    logic [SUM_W-1:0]    s_reg;
    logic [MC_W-1:0]     acc_reg;
    logic [MC_W-1:0]     mcand_reg;
    logic [31:0]         mplier_reg;
    logic [MC_W-1:0]     den_reg;
    logic [RM_W-1:0]     rem_reg;
    logic [DENS_W-1:0]   q_reg;
    logic [DENS_W-1:0]   res_d_reg;
    logic                res_sat_reg;

    logic                out_valid_reg;
    logic [SHELL_W-1:0]  shell_index_reg;
    logic [DENS_W-1:0]   density_reg;
    logic                saturated_reg;
    logic                last_reg;

    logic [NW-1:0]       n_used;
    logic [NS-1:0]       hit;
    logic [IW-1:0]       hit_idx;
    logic                hit_any;
    logic [SQ_W-1:0]     area [NS];
    logic [NS-1:0]       empty;
    logic [IW-1:0]       sidx;
    logic [SUM_W-1:0]    sum_rd;
    logic [SUM_W:0]      sum_add;
    logic signed [DZ_W-1:0] dz;
    logic                dz_pos;
    logic [MC_W-1:0]     acc_add;
    logic [RM_W-1:0]     rem_sh;
    logic                rem_ge;
    logic [RM_W-1:0]     num_top;
    logic                is_last;
    logic                emit_go;

    always_comb
    begin
        if (32'(cfg.edge_count) < 2)
        begin
            n_used = NW'(2);
        end
        else if (32'(cfg.edge_count) > MAX_EDGES)
        begin
            n_used = NW'(MAX_EDGES);
        end
        else
        begin
            n_used = NW'(cfg.edge_count);
        end
    end

    // one compare lane per shell, lowest matching shell wins
    always_comb
    begin
        for (int j = 0; j < NS; j++)
        begin
            hit[j]   = (j + 1 < int'(n_used)) &&
                       ({2'b00, sq_reg[j]} < job.r2) && (job.r2 <= {2'b00, sq_reg[j+1]});
            area[j]  = sq_reg[j+1] - sq_reg[j];
            empty[j] = (sq_reg[j+1] <= sq_reg[j]);
        end
        hit_idx = '0;
        hit_any = 1'b0;
        for (int j = NS - 1; j >= 0; j--)
        begin
            if (hit[j])
            begin
                hit_idx = IW'(j);
                hit_any = 1'b1;
            end
        end
    end

    assign sidx    = (state_reg == ST_CHG) ? hit_idx_reg : i_reg;
    assign sum_rd  = sums_reg[sidx];
    assign sum_add = {1'b0, sum_rd} + {{(SUM_W + 1 - WEIGHT_W){1'b0}}, weight_reg};

    assign dz      = DZ_W'(cfg.z_max) - DZ_W'(cfg.z_min);
    assign dz_pos  = !dz[DZ_W-1] && (dz != '0);

    assign acc_add = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign rem_sh  = {rem_reg[RM_W-2:0], 1'b0};
    assign rem_ge  = (rem_sh >= {1'b0, den_reg});
    assign num_top = {{(RM_W - SUM_W - 22){1'b0}}, s_reg, 22'd0};

    assign is_last = (NW1'(i_reg) + NW1'(2)) == NW1'(n_used);
    assign emit_go = !out_valid_reg || out_ready;

    assign job_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < NS; j++)
            begin
                sums_reg[j] <= '0;
            end
        end
        else
        begin
            // in ST_EMIT the output valid is handled by the state below
            if (out_valid_reg && out_ready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        case (job.kind)
                            KIND_CHARGE: state_reg <= ST_CHG;
                            KIND_FINISH: state_reg <= ST_FLOAD;
                            default:     state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_CHG:
                begin
                    if (hit_any_reg)
                    begin
                        sums_reg[hit_idx_reg] <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                    end
                    state_reg <= ST_IDLE;
                end
                ST_FLOAD:
                begin
                    if (!dz_pos || empty[i_reg])
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1:
                begin
                    if (cnt_reg == 5'd23)
                    begin
                        state_reg <= ST_MUL2;
                    end
                end
                ST_MUL2:
                begin
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK:
                begin
                    state_reg <= (num_top >= {1'b0, den_reg}) ? ST_EMIT : ST_DIV;
                end
                ST_DIV:
                begin
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg <= 1'b1;
                        if (is_last)
                        begin
                            for (int j = 0; j < NS; j++)
                            begin
                                sums_reg[j] <= '0;
                            end
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_FLOAD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    if (job.kind == KIND_LOAD)
                    begin
                        sq_reg[IW'(job.edge_idx)] <= job.radius * job.radius;
                    end
                    hit_idx_reg <= hit_idx;
                    hit_any_reg <= hit_any;
                    weight_reg  <= job.weight;
                    i_reg       <= '0;
                end
            end
            ST_CHG: ;
            ST_FLOAD:
            begin
                s_reg       <= sum_rd;
                mcand_reg   <= MC_W'(area[i_reg]);
                mplier_reg  <= 32'(dz[COORD_W-1:0]);
                acc_reg     <= '0;
                cnt_reg     <= '0;
                res_d_reg   <= '1;
                res_sat_reg <= 1'b1;
            end
            ST_MUL1:
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd23)
                begin
                    mcand_reg  <= acc_add;
                    mplier_reg <= PI_Q30;
                    acc_reg    <= '0;
                    cnt_reg    <= '0;
                end
                else
                begin
                    acc_reg    <= acc_add;
                    mcand_reg  <= {mcand_reg[MC_W-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[31:1]};
                end
            end
            ST_MUL2:
            begin
                cnt_reg    <= cnt_reg + 5'd1;
                acc_reg    <= acc_add;
                mcand_reg  <= {mcand_reg[MC_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[31:1]};
                if (cnt_reg == 5'd31)
                begin
                    den_reg <= acc_add;
                end
            end
            ST_CHK:
            begin
                rem_reg <= num_top;
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                cnt_reg <= cnt_reg + 5'd1;
                rem_reg <= rem_ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                q_reg   <= {q_reg[DENS_W-2:0], rem_ge};
                if (cnt_reg == 5'd31)
                begin
                    res_d_reg   <= {q_reg[DENS_W-2:0], rem_ge};
                    res_sat_reg <= 1'b0;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    shell_index_reg <= SHELL_W'(i_reg);
                    density_reg     <= res_d_reg;
                    saturated_reg   <= res_sat_reg;
                    last_reg        <= is_last;
                    i_reg           <= i_reg + IW'(1);
                end
            end
            default: ;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign shell_index = shell_index_reg;
    assign density     = density_reg;
    assign saturated   = saturated_reg;
    assign last        = last_reg;

endmodule

// ----- src/radial_shell_density_histogram.sv -----
// channel  | handshake                 | payload
// input    | in_valid / in_ready       | kind, edge_index, edge_radius, pos_x/y/z,
//          |                           | charge_type, weight
// output   | out_valid / out_ready     | shell_index, density, saturated, last
// config   | cfg_we (no wait)          | cfg_index, cfg_data
//
// Charge word path: input stage, queue, shell compare, sum update. Finish: for
// each shell, the shared shift-add multiplier (24 + 32 steps), then the 32-step
// restoring divider; an empty shell, z_max <= z_min or an overflow saturates.
// Reset clears control state and shell sums and resets the config registers
// (edge count to 2); edge radii are undefined until loaded. A 2-deep queue lets
// the front keep taking words while the back stalls on a full output register.
module radial_shell_density_histogram #(
    parameter int MAX_EDGES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        kind,
    input  logic [rsdh_pkg::EIDX_W-1:0]       edge_index,
    input  logic [rsdh_pkg::RADIUS_W-1:0]     edge_radius,
    input  logic signed [rsdh_pkg::COORD_W-1:0] pos_x,
    input  logic signed [rsdh_pkg::COORD_W-1:0] pos_y,
    input  logic signed [rsdh_pkg::COORD_W-1:0] pos_z,
    input  logic [rsdh_pkg::TYPE_W-1:0]       charge_type,
    input  logic [rsdh_pkg::WEIGHT_W-1:0]     weight,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rsdh_pkg::SHELL_W-1:0]      shell_index,
    output logic [rsdh_pkg::DENS_W-1:0]       density,
    output logic                              saturated,
    output logic                              last,
    input  logic                              cfg_we,
    input  logic [rsdh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsdh_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rsdh_pkg::*;

    cfg_t cfg;
    job_t f_job;
    job_t b_job;
    logic f_valid;
    logic f_ready;
    logic b_valid;
    logic b_ready;

    rsdh_front #(.MAX_EDGES(MAX_EDGES)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .edge_index  (edge_index),
        .edge_radius (edge_radius),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .charge_type (charge_type),
        .weight      (weight),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cfg         (cfg),
        .job_valid   (f_valid),
        .job_ready   (f_ready),
        .job         (f_job)
    );

    rsdh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_job    (b_job)
    );

    rsdh_back #(.MAX_EDGES(MAX_EDGES)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (b_valid),
        .job_ready   (b_ready),
        .job         (b_job),
        .cfg         (cfg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .shell_index (shell_index),
        .density     (density),
        .saturated   (saturated),
        .last        (last)
    );

endmodule
